@@ sv/gated_rpm_tachometer_defines.svh @@
// Assertion macros for the tachometer top level.
`ifndef GATED_RPM_TACHOMETER_DEFINES_SVH
`define GATED_RPM_TACHOMETER_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define GRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tachometer same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define GRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tachometer next-cycle check failed");

`endif

@@ sv/grt_pkg.sv @@
package grt_pkg;

    // Fixed field widths
    localparam int FREQ_W     = 22;
    localparam int RPM_W      = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int POLE_W     = 8;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
    localparam logic [RPM_W-1:0]  RPM_MAX  = {RPM_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLES   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_RST  = 22'd1000000;
    localparam logic [CFG_DATA_W-1:0] TIMEOUT_RST = 22'd1500000;
    localparam logic [POLE_W-1:0]     POLES_RST   = 8'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // take the input word and update counters
        logic div_step;  // run one divider step
        logic div_done;  // last divider step, write the rpm hold
        logic emit;      // load the output register from the holds
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic latch;     // the offered word closes the gate window
    } dp_status_t;

endpackage

@@ sv/grt_datapath.sv @@
module grt_datapath #(
    parameter int TIME_WIDTH = 22,
    parameter int RPM_SCALE  = 60,
    parameter int PROD_W     = 28
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  grt_pkg::dp_cmd_t               cmd,
    output grt_pkg::dp_status_t            status,
    input  logic                           in_tick,
    input  logic                           in_edge,
    input  logic                           cfg_we,
    input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [grt_pkg::FREQ_W-1:0]     out_freq,
    output logic [grt_pkg::RPM_W-1:0]      out_rpm,
    output logic                           out_updated
);
    import grt_pkg::*;

    localparam int CMP_W   = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;
    localparam int SATF_W  = (TIME_WIDTH > FREQ_W) ? TIME_WIDTH : FREQ_W;
    localparam int SATR_W  = (PROD_W > RPM_W) ? PROD_W : RPM_W;

    logic [CFG_DATA_W-1:0] window_reg, timeout_reg;
    logic [POLE_W-1:0]     pole_reg;

    logic [TIME_WIDTH-1:0] pulse_reg, pulse_next;
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [FREQ_W-1:0]     freq_hold_reg, freq_hold_next;
    logic [RPM_W-1:0]      rpm_hold_reg, rpm_hold_next;
    logic [PROD_W-1:0]     dvd_reg, dvd_next;
    logic [POLE_W-1:0]     rem_reg, rem_next;

    logic [FREQ_W-1:0]     out_freq_reg;
    logic [RPM_W-1:0]      out_rpm_reg;
    logic                  out_upd_reg, upd_reg, upd_next;

    logic [TIME_WIDTH-1:0] el_inc, pc_inc;
    logic                  latch;
    logic [SATF_W-1:0]     pc_ext;
    logic [FREQ_W-1:0]     freq_sat;
    logic [PROD_W-1:0]     product;
    logic [POLE_W-1:0]     divisor;
    logic [POLE_W:0]       rem_shift, rem_sub;
    logic                  q_bit;
    logic [SATR_W-1:0]     quot_ext;
    logic [RPM_W-1:0]      rpm_sat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RST;
            timeout_reg <= TIMEOUT_RST;
            pole_reg    <= POLES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:  window_reg  <= cfg_data;
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_POLES:   pole_reg    <= cfg_data[POLE_W-1:0];
                default:     ;
            endcase
        end
    end

    // Saturating counter advance and window check
    always_comb
    begin
        el_inc = elapsed_reg;
        if (in_tick && (elapsed_reg != {TIME_WIDTH{1'b1}}))
            el_inc = elapsed_reg + TIME_WIDTH'(1);
        pc_inc = pulse_reg;
        if (in_edge && (pulse_reg != {TIME_WIDTH{1'b1}}))
            pc_inc = pulse_reg + TIME_WIDTH'(1);
        latch = in_edge && (CMP_W'(el_inc) > CMP_W'(window_reg));
    end

    assign status.latch = latch;

    // Clamp the count to the frequency field and scale it for the divider
    assign pc_ext   = SATF_W'(pc_inc);
    assign freq_sat = (pc_ext > SATF_W'(FREQ_MAX)) ? FREQ_MAX : pc_ext[FREQ_W-1:0];
    assign product  = PROD_W'(pc_inc) * PROD_W'(RPM_SCALE);

    // One restoring divide step: quotient bits shift into the dividend register
    assign divisor   = (pole_reg == '0) ? POLE_W'(1) : pole_reg;
    assign rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign q_bit     = (rem_shift >= {1'b0, divisor});

    always_comb
    begin
        pulse_next     = pulse_reg;
        elapsed_next   = elapsed_reg;
        freq_hold_next = freq_hold_reg;
        rpm_hold_next  = rpm_hold_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        upd_next       = upd_reg;
        quot_ext       = '0;
        rpm_sat        = '0;

        if (cmd.accept)
        begin
            if (latch)
            begin
                // Close the window: hold the count, start the rpm divide
                pulse_next     = '0;
                elapsed_next   = '0;
                freq_hold_next = freq_sat;
                dvd_next       = product;
                rem_next       = '0;
                upd_next       = 1'b1;
            end
            else
            begin
                pulse_next   = pc_inc;
                elapsed_next = el_inc;
                upd_next     = 1'b0;
                // Drop stale measurements
                if (CMP_W'(el_inc) > CMP_W'(timeout_reg))
                begin
                    freq_hold_next = '0;
                    rpm_hold_next  = '0;
                end
            end
        end

        if (cmd.div_step)
        begin
            rem_next = q_bit ? rem_sub[POLE_W-1:0] : rem_shift[POLE_W-1:0];
            dvd_next = {dvd_reg[PROD_W-2:0], q_bit};
        end

        if (cmd.div_done)
        begin
            quot_ext      = SATR_W'(dvd_next);
            rpm_sat       = (quot_ext > SATR_W'(RPM_MAX)) ? RPM_MAX : quot_ext[RPM_W-1:0];
            rpm_hold_next = rpm_sat;
        end
    end

    // Measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg     <= '0;
            elapsed_reg   <= '0;
            freq_hold_reg <= '0;
            rpm_hold_reg  <= '0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            pulse_reg     <= pulse_next;
            elapsed_reg   <= elapsed_next;
            freq_hold_reg <= freq_hold_next;
            rpm_hold_reg  <= rpm_hold_next;
            upd_reg       <= upd_next;
        end
    end

    // Divider and output payload
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (cmd.emit)
        begin
            out_freq_reg <= freq_hold_reg;
            out_rpm_reg  <= rpm_hold_reg;
            out_upd_reg  <= upd_reg;
        end
    end

    assign out_freq    = out_freq_reg;
    assign out_rpm     = out_rpm_reg;
    assign out_updated = out_upd_reg;

endmodule

@@ sv/grt_ctrl.sv @@
module grt_ctrl #(
    parameter int DIV_STEPS = 28
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  grt_pkg::dp_status_t status,
    output grt_pkg::dp_cmd_t    cmd
);
    import grt_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;
    logic             slot_free;

    assign slot_free = !mvalid_reg || m_tready;

    // Sequence one word: update, optional divide, then emit
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        mvalid_next  = mvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = status.latch ? ST_DIV : ST_EMIT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.div_done = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

@@ sv/gated_rpm_tachometer.sv @@
// Flow: ST_IDLE accepts one input word and ST_EMIT loads the registered result; when a word
//   closes the window, ST_DIV runs the divide between them, and ST_EMIT waits for a free slot.
// Input: a new word is not taken until the result of the last one is emitted; a window close
//   adds the bit-serial divide by pole_count (one quotient bit per cycle).
// Reset (rst_n, async, active low): counters and held values clear, registers return
//   to window 1000000, timeout 1500000, pole count 1; no clearing pass.
`include "gated_rpm_tachometer_defines.svh"

module gated_rpm_tachometer #(
    parameter int TIME_WIDTH = 22,
    parameter int RPM_SCALE  = 60
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] tick, [1] rising_edge
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,   // [21:0] pulses_per_window, [49:22] rpm
    output logic                           m_tuser,   // [0] updated
    input  logic                           cfg_we,
    input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import grt_pkg::*;

    localparam int SCALE_W = $clog2(RPM_SCALE + 1);
    localparam int PROD_W  = TIME_WIDTH + SCALE_W;

    dp_cmd_t              cmd;
    dp_status_t           status;
    logic [FREQ_W-1:0]    out_freq;
    logic [RPM_W-1:0]     out_rpm;
    logic                 out_updated;

    grt_ctrl #(
        .DIV_STEPS (PROD_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grt_datapath #(
        .TIME_WIDTH (TIME_WIDTH),
        .RPM_SCALE  (RPM_SCALE),
        .PROD_W     (PROD_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_tick     (s_tdata[0]),
        .in_edge     (s_tdata[1]),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_freq    (out_freq),
        .out_rpm     (out_rpm),
        .out_updated (out_updated)
    );

    assign m_tdata = {6'b0, out_rpm, out_freq};
    assign m_tuser = out_updated;

    // One word in flight: no accept right after an accept
    `GRT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    // A fresh measurement counts at least one edge
    `GRT_ASSERT_NOW(a_update_nonzero, m_tvalid && m_tuser, m_tdata[21:0] != 22'd0)
    // Zero pulses always pairs with zero rpm
    `GRT_ASSERT_NOW(a_zero_pair, m_tvalid && (m_tdata[21:0] == 22'd0),
                    m_tdata[49:22] == 28'd0)

endmodule

@@ tb/rpm_reading_checker.sv @@
`timescale 1ns / 100ps

module rpm_reading_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] tick, [1] rising_edge
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [55:0]                    m_tdata,   // [21:0] pulses_per_window, [49:22] rpm
    input  logic                           m_tuser,   // [0] updated
    input  logic                           cfg_we,
    input  logic [grt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             readings_owed,
    output int                             latches_seen,
    output int                             stale_clears
);
    import grt_pkg::*;

    localparam int TICK_W    = 22;
    localparam int RPM_SCALE = 60;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [RPM_W-1:0]  rpm;
        logic              updated;
    } reading_t;

    reading_t expected_readings[$];

    // Shadow copy of the gate settings and the counters
    logic [CFG_DATA_W-1:0] window_us;
    logic [CFG_DATA_W-1:0] timeout_us;
    logic [POLE_W-1:0]     poles;
    logic [TICK_W-1:0]     pulse_count;
    logic [TICK_W-1:0]     elapsed_us;
    logic [FREQ_W-1:0]     freq_hold;
    logic [RPM_W-1:0]      rpm_hold;

    int mismatch_count = 0;
    int latch_count    = 0;
    int stale_count    = 0;

    function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] v);
        return (v == TICK_MAX) ? v : v + 1'b1;
    endfunction

    // Advance the shadow counters by one sensor word and return the reading it yields
    function reading_t next_reading(input logic tick, input logic pulse);
        logic [63:0] divisor;
        logic [63:0] scaled;
        reading_t    r;
        r.updated = 1'b0;
        if (tick)
            elapsed_us = bump(elapsed_us);
        if (pulse) begin
            pulse_count = bump(pulse_count);
            if (elapsed_us > window_us) begin
                // a pole count of zero divides as one
                divisor   = (poles == '0) ? 64'd1 : 64'(poles);
                scaled    = (64'(pulse_count) * 64'(RPM_SCALE)) / divisor;
                freq_hold = pulse_count;
                rpm_hold  = (scaled > 64'(RPM_MAX)) ? RPM_MAX : scaled[RPM_W-1:0];
                pulse_count = '0;
                elapsed_us  = '0;
                r.updated   = 1'b1;
                latch_count++;
            end
        end
        // zero the holds once the window has gone stale
        if (elapsed_us > timeout_us) begin
            if (freq_hold != '0 || rpm_hold != '0)
                stale_count++;
            freq_hold = '0;
            rpm_hold  = '0;
        end
        r.freq = freq_hold;
        r.rpm  = rpm_hold;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("reading mismatch on %s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Track config writes, predict on accepted input words, compare accepted results
    always @(posedge clk or negedge rst_n) begin : watch
        reading_t want;
        if (!rst_n) begin
            window_us   = WINDOW_RST;
            timeout_us  = TIMEOUT_RST;
            poles       = POLES_RST;
            pulse_count = '0;
            elapsed_us  = '0;
            freq_hold   = '0;
            rpm_hold    = '0;
            expected_readings.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WINDOW:  window_us  = cfg_data;
                    CFG_TIMEOUT: timeout_us = cfg_data;
                    CFG_POLES:   poles      = cfg_data[POLE_W-1:0];
                    default:     ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_readings.push_back(next_reading(s_tdata[0], s_tdata[1]));
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("reading arrived with none expected: freq %0d rpm %0d upd %0d",
                                 m_tdata[21:0], m_tdata[49:22], m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("pulses_per_window", 64'(want.freq), 64'(m_tdata[21:0]));
                    check_field("rpm", 64'(want.rpm), 64'(m_tdata[49:22]));
                    check_field("updated", 64'(want.updated), 64'(m_tuser));
                end
            end
        end
        mismatches    <= mismatch_count;
        readings_owed <= expected_readings.size();
        latches_seen  <= latch_count;
        stale_clears  <= stale_count;
    end

endmodule

@@ tb/tb_gated_rpm_tachometer.sv @@
`timescale 1ns / 100ps

module tb_gated_rpm_tachometer;
    import grt_pkg::*;

    localparam int SETTLE_CYCLES = 40;    // longer than the latency of a window close
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 150;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = 2'd3;
    localparam logic [CFG_DATA_W-1:0] DATA_FULL  = {CFG_DATA_W{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [0] tick, [1] rising_edge
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;   // [21:0] pulses_per_window, [49:22] rpm
    logic                  m_tuser;   // [0] updated
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int readings_owed;
    int latches_seen;
    int stale_clears;

    bit no_gaps = 1'b0;
    int hold_asks = 0;
    int hold_done = 0;
    int words_sent = 0;
    int settings_used = 0;

    gated_rpm_tachometer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rpm_reading_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .readings_owed (readings_owed),
        .latches_seen  (latches_seen),
        .stale_clears  (stale_clears)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_done)
            begin
                repeat (HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
                hold_done++;
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 19);
        end
    end

    // Offer one sensor word, with random gaps ahead of it, and hold it until taken
    task automatic offer_word(input bit tick, input bit pulse);
        while (!no_gaps && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pulse, tick};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait until every expected reading has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (readings_owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Program window, timeout and pole count, then release the write enable
    task automatic set_gate(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] tmo,
                            input logic [CFG_DATA_W-1:0] pol);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_POLES, pol);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [CFG_DATA_W-1:0] win;
        logic [CFG_DATA_W-1:0] tmo;
        logic [CFG_DATA_W-1:0] pol;
        int                    tick_pct;
        int                    pulse_pct;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every tick/edge combination, no window can close
        offer_word(1'b0, 1'b0);
        offer_word(1'b1, 1'b0);
        offer_word(1'b0, 1'b1);
        offer_word(1'b1, 1'b1);

        // One-tick window, longest timeout, most poles; an unused index must be ignored
        settle();
        write_reg(CFG_UNUSED, 22'd2);
        set_gate(22'd1, DATA_FULL, 22'd255);
        offer_word(1'b1, 1'b1);
        offer_word(1'b1, 1'b1);
        offer_word(1'b1, 1'b0);
        offer_word(1'b1, 1'b0);
        offer_word(1'b0, 1'b1);

        // Window at full scale never closes; a one-tick timeout clears the holds
        settle();
        set_gate(DATA_FULL, 22'd1, 22'h3FFF05);
        offer_word(1'b1, 1'b1);
        offer_word(1'b1, 1'b1);

        // Zero pole count divides as one; go stale, then latch again
        settle();
        set_gate(22'd2, 22'd3, 22'd0);
        repeat (3) offer_word(1'b1, 1'b1);
        repeat (4) offer_word(1'b1, 1'b0);
        offer_word(1'b0, 1'b1);

        // Random phases, each under its own gate setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            settle();
            case (ph % 5)
                0:       win = 22'd1;
                1:       win = CFG_DATA_W'($urandom_range(2, 40));
                2:       win = CFG_DATA_W'($urandom_range(40, 300));
                3:       win = (ph < 5) ? 22'd4000000 : DATA_FULL;
                default: win = CFG_DATA_W'($urandom_range(1, 15));
            endcase
            case ($urandom_range(3))
                0:       tmo = 22'd1;
                1:       tmo = win + CFG_DATA_W'($urandom_range(0, 30));
                2:       tmo = CFG_DATA_W'($urandom_range(1, 60));
                default: tmo = DATA_FULL;
            endcase
            case ($urandom_range(4))
                0:       pol = 22'd1;
                1:       pol = 22'd255;
                2:       pol = 22'd0;
                default: pol = CFG_DATA_W'($urandom_range(2, 254));
            endcase
            set_gate(win, tmo, pol);
            no_gaps   = (ph == 2);
            tick_pct  = $urandom_range(30, 100);
            pulse_pct = $urandom_range(10, 100);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // stall the result side long enough to back up the input
                if (ph == 4 && n == 20)
                    hold_asks++;
                // pause mid-phase until the pipeline is empty
                if (ph == 6 && n == 75)
                    settle();
                offer_word($urandom_range(99) < tick_pct, $urandom_range(99) < pulse_pct);
            end
        end
        no_gaps = 1'b0;
        settle();

        $display("Run sent %0d sensor words under %0d gate settings, from one tick to full scale.",
                 words_sent, settings_used);
        $display("It saw %0d readings latched and %0d held readings cleared as stale.",
                 latches_seen, stale_clears);
        if (mismatches == 0 && readings_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("Timeout waiting for the tachometer");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ gated_rpm_tachometer.f @@
+incdir+sv
sv/grt_pkg.sv
sv/grt_datapath.sv
sv/grt_ctrl.sv
sv/gated_rpm_tachometer.sv
tb/rpm_reading_checker.sv
tb/tb_gated_rpm_tachometer.sv
